[src/dlog_pkg.sv]
// shared types and constants of the discrete logarithm block
package dlog_pkg;

    localparam int MOD_BITS   = 32;
    localparam int K_BITS     = 17;
    localparam int SLOT_BITS  = 17;
    localparam int EPOCH_BITS = 8;
    localparam int EXP_BITS   = 33;
    localparam int CNT_BITS   = $clog2(MOD_BITS);

    // hash multiplier split into a low word and the low bits of the high word
    localparam logic [31:0]          HASH_LO = 32'h7F4A7C15;
    localparam logic [SLOT_BITS-1:0] HASH_HI = 17'h179B9;

    typedef struct packed {
        logic [MOD_BITS-1:0] base;
        logic [MOD_BITS-1:0] target;
        logic [MOD_BITS-1:0] modulus;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [EXP_BITS-1:0] exponent;
    } out_item_t;

    typedef struct packed {
        logic                start;
        logic [MOD_BITS-1:0] a;
        logic [MOD_BITS-1:0] x;
        logic [MOD_BITS-1:0] m;
    } mm_req_t;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [K_BITS-1:0]     p;
        logic [MOD_BITS-1:0]   val;
    } slot_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RED_B,
        ST_RED_T,
        ST_SQRT,
        ST_POW_MUL,
        ST_POW_SQ,
        ST_HASH1,
        ST_HASH2,
        ST_PRB_RD,
        ST_PRB_CHK,
        ST_GIANT_MUL,
        ST_BABY_MUL,
        ST_EXP1,
        ST_EXP2,
        ST_OUT
    } state_t;

endpackage

[src/dlog_mulmod.sv]
// bit-serial modular multiplier: (a * x) mod m, one bit of x per cycle, a < m
module dlog_mulmod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dlog_pkg::mm_req_t             req,
    output logic                          done,
    output logic [dlog_pkg::MOD_BITS-1:0] r
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [dlog_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [dlog_pkg::MOD_BITS-1:0] r_reg, r_next;
    logic [dlog_pkg::MOD_BITS-1:0] a_reg, a_next;
    logic [dlog_pkg::MOD_BITS-1:0] x_reg, x_next;
    logic [dlog_pkg::MOD_BITS-1:0] m_reg, m_next;
    logic [dlog_pkg::MOD_BITS:0]   dbl;
    logic [dlog_pkg::MOD_BITS:0]   dbl_red;
    logic [dlog_pkg::MOD_BITS:0]   sum;
    logic [dlog_pkg::MOD_BITS:0]   sum_red;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        a_reg <= a_next;
        x_reg <= x_next;
        m_reg <= m_next;
    end

    // one step: r = 2r mod m, then add a when the top bit of x is set
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum     = dbl_red + (x_reg[dlog_pkg::MOD_BITS-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
    end

    // sequencing of the steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        x_next    = x_reg;
        m_next    = m_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            r_next    = '0;
            a_next    = req.a;
            x_next    = req.x;
            m_next    = req.m;
        end
        else if (busy_reg)
        begin
            r_next   = sum_red[dlog_pkg::MOD_BITS-1:0];
            x_next   = {x_reg[dlog_pkg::MOD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dlog_pkg::CNT_BITS'(dlog_pkg::MOD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign r    = r_reg;

endmodule

[src/discrete_log_bsgs.sv]
// top level of the baby-step giant-step discrete logarithm solver
//
// One query at a time: in_ready is high only while the block is idle, and the
// result waits in an output register until it is taken. All modular products go
// through one bit-serial multiplier. A product is issued, runs 32 steps, and then
// its answer is taken. With k = floor(sqrt(modulus)) + 1 a query needs up to
// 2 + 2*17 + 2*k products. Each hash lookup reads one slot, and one more for every
// further probe. Matches are found through a 131072-slot hash table in on-chip
// memory whose slots carry an 8-bit epoch mark. The first query after reset, and
// again every 255 queries with a non-zero modulus after that, first runs a
// clearing pass over every slot of the table.
module discrete_log_bsgs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dlog_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dlog_pkg::out_item_t out_data
);

    localparam int MB = dlog_pkg::MOD_BITS;
    localparam int KB = dlog_pkg::K_BITS;
    localparam int SB = dlog_pkg::SLOT_BITS;
    localparam int EB = dlog_pkg::EPOCH_BITS;
    localparam int XB = dlog_pkg::EXP_BITS;

    dlog_pkg::state_t      state_reg, state_next;
    logic [EB-1:0]         epoch_reg, epoch_next;
    logic                  issued_reg, issued_next;
    logic                  baby_reg, baby_next;
    logic [MB-1:0]         b_reg, b_next;
    logic [MB-1:0]         t_reg, t_next;
    logic [MB-1:0]         m_reg, m_next;
    logic [KB-1:0]         k_reg, k_next;
    logic [MB-1:0]         rem_reg, rem_next;
    logic [MB-1:0]         res_reg, res_next;
    logic [MB-1:0]         bit_reg, bit_next;
    logic [KB-1:0]         e_reg, e_next;
    logic [MB-1:0]         acc_reg, acc_next;
    logic [MB-1:0]         pb_reg, pb_next;
    logic [MB-1:0]         gf_reg, gf_next;
    logic [MB-1:0]         run_reg, run_next;
    logic [KB-1:0]         p_reg, p_next;
    logic [KB-1:0]         q_reg, q_next;
    logic [KB-1:0]         hit_reg, hit_next;
    logic [2*MB-1:0]       hprod_reg, hprod_next;
    logic [2*KB-1:0]       prod_reg, prod_next;
    logic [SB-1:0]         slot_reg, slot_next;
    dlog_pkg::out_item_t   out_reg, out_next;
    dlog_pkg::slot_entry_t rdata_reg;
    dlog_pkg::slot_entry_t wdata;
    logic                  mem_we;
    dlog_pkg::mm_req_t     mm_req;
    logic                  mm_done;
    logic [MB-1:0]         mm_r;
    logic [MB-1:0]         one_mod;
    logic [MB-1:0]         sq_try;
    logic [2*SB-1:0]       hash_hi_prod;
    logic                  slot_valid;
    logic                  slot_match;

    // hash slot store, one read and one write port
    dlog_pkg::slot_entry_t slot_mem [2**SB];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[slot_reg] <= wdata;
        end
        rdata_reg <= slot_mem[slot_reg];
    end

    // shared modular multiplier
    dlog_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .done  (mm_done),
        .r     (mm_r)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dlog_pkg::ST_IDLE;
            epoch_reg  <= '1;
            issued_reg <= 1'b0;
            baby_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            epoch_reg  <= epoch_next;
            issued_reg <= issued_next;
            baby_reg   <= baby_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        t_reg     <= t_next;
        m_reg     <= m_next;
        k_reg     <= k_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        e_reg     <= e_next;
        acc_reg   <= acc_next;
        pb_reg    <= pb_next;
        gf_reg    <= gf_next;
        run_reg   <= run_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        hit_reg   <= hit_next;
        hprod_reg <= hprod_next;
        prod_reg  <= prod_next;
        slot_reg  <= slot_next;
        out_reg   <= out_next;
    end

    // small helpers
    always_comb
    begin
        one_mod      = (m_reg == MB'(1)) ? '0 : MB'(1);
        sq_try       = res_reg + bit_reg;
        hash_hi_prod = (2*SB)'(run_reg[SB-1:0]) * (2*SB)'(dlog_pkg::HASH_HI);
        slot_valid   = (rdata_reg.tag == epoch_reg);
        slot_match   = slot_valid && (rdata_reg.val == run_reg);
    end

    // multiplier requests
    always_comb
    begin
        mm_req.start = 1'b0;
        mm_req.a     = run_reg;
        mm_req.x     = run_reg;
        mm_req.m     = m_reg;
        unique case (state_reg)
            dlog_pkg::ST_RED_B:
            begin
                mm_req.start = !issued_reg;
                mm_req.a     = one_mod;
                mm_req.x     = b_reg;
            end
            dlog_pkg::ST_RED_T:
            begin
                mm_req.start = !issued_reg;
                mm_req.a     = one_mod;
                mm_req.x     = t_reg;
            end
            dlog_pkg::ST_POW_MUL:
            begin
                mm_req.start = !issued_reg && (e_reg != '0) && e_reg[0];
                mm_req.a     = acc_reg;
                mm_req.x     = pb_reg;
            end
            dlog_pkg::ST_POW_SQ:
            begin
                mm_req.start = !issued_reg;
                mm_req.a     = pb_reg;
                mm_req.x     = pb_reg;
            end
            dlog_pkg::ST_GIANT_MUL:
            begin
                mm_req.start = !issued_reg;
                mm_req.a     = run_reg;
                mm_req.x     = gf_reg;
            end
            dlog_pkg::ST_BABY_MUL:
            begin
                mm_req.start = !issued_reg;
                mm_req.a     = run_reg;
                mm_req.x     = b_reg;
            end
            default:
            begin
                mm_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        epoch_next  = epoch_reg;
        issued_next = issued_reg;
        baby_next   = baby_reg;
        b_next      = b_reg;
        t_next      = t_reg;
        m_next      = m_reg;
        k_next      = k_reg;
        rem_next    = rem_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        pb_next     = pb_reg;
        gf_next     = gf_reg;
        run_next    = run_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        hit_next    = hit_reg;
        hprod_next  = hprod_reg;
        prod_next   = prod_reg;
        slot_next   = slot_reg;
        out_next    = out_reg;
        mem_we      = 1'b0;
        wdata.tag   = epoch_reg;
        wdata.p     = p_reg;
        wdata.val   = run_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;

        if (mm_req.start)
        begin
            issued_next = 1'b1;
        end
        if (mm_done)
        begin
            issued_next = 1'b0;
        end

        unique case (state_reg)
            dlog_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    b_next = in_data.base;
                    t_next = in_data.target;
                    m_next = in_data.modulus;
                    if (in_data.modulus == '0)
                    begin
                        out_next   = '0;
                        state_next = dlog_pkg::ST_OUT;
                    end
                    else if (epoch_reg == '1)
                    begin
                        // epoch marks used up: sweep the store first
                        epoch_next = EB'(1);
                        slot_next  = '0;
                        state_next = dlog_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                        state_next = dlog_pkg::ST_RED_B;
                    end
                end
            end

            dlog_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                wdata.tag = '0;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == '1)
                begin
                    state_next = dlog_pkg::ST_RED_B;
                end
            end

            // reduce base and target modulo the modulus
            dlog_pkg::ST_RED_B:
            begin
                if (mm_done)
                begin
                    b_next     = mm_r;
                    state_next = dlog_pkg::ST_RED_T;
                end
            end

            dlog_pkg::ST_RED_T:
            begin
                if (mm_done)
                begin
                    t_next     = mm_r;
                    rem_next   = m_reg;
                    res_next   = '0;
                    bit_next   = MB'(1) << (MB - 2);
                    state_next = dlog_pkg::ST_SQRT;
                end
            end

            // integer square root, two bits per step
            dlog_pkg::ST_SQRT:
            begin
                if (bit_reg != '0)
                begin
                    if (rem_reg >= sq_try)
                    begin
                        rem_next = rem_reg - sq_try;
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                else
                begin
                    k_next     = res_reg[KB-1:0] + 1'b1;
                    e_next     = res_reg[KB-1:0] + 1'b1;
                    acc_next   = one_mod;
                    pb_next    = b_reg;
                    state_next = dlog_pkg::ST_POW_MUL;
                end
            end

            // giant factor base^k by square and multiply
            dlog_pkg::ST_POW_MUL:
            begin
                if (e_reg == '0)
                begin
                    gf_next    = acc_reg;
                    run_next   = acc_reg;
                    p_next     = KB'(1);
                    baby_next  = 1'b0;
                    state_next = dlog_pkg::ST_HASH1;
                end
                else if (!e_reg[0])
                begin
                    state_next = dlog_pkg::ST_POW_SQ;
                end
                else if (mm_done)
                begin
                    acc_next   = mm_r;
                    state_next = dlog_pkg::ST_POW_SQ;
                end
            end

            dlog_pkg::ST_POW_SQ:
            begin
                if (mm_done)
                begin
                    pb_next    = mm_r;
                    e_next     = e_reg >> 1;
                    state_next = dlog_pkg::ST_POW_MUL;
                end
            end

            // hash of the running value: low-word product in HASH1, slot in HASH2
            dlog_pkg::ST_HASH1:
            begin
                hprod_next = (2*MB)'(run_reg) * (2*MB)'(dlog_pkg::HASH_LO);
                state_next = dlog_pkg::ST_HASH2;
            end

            dlog_pkg::ST_HASH2:
            begin
                slot_next  = hprod_reg[MB+SB-1:MB] + hash_hi_prod[SB-1:0];
                state_next = dlog_pkg::ST_PRB_RD;
            end

            dlog_pkg::ST_PRB_RD:
            begin
                state_next = dlog_pkg::ST_PRB_CHK;
            end

            // linear probing, shared by insertion and lookup
            dlog_pkg::ST_PRB_CHK:
            begin
                if (slot_match)
                begin
                    if (baby_reg)
                    begin
                        hit_next   = rdata_reg.p;
                        state_next = dlog_pkg::ST_EXP1;
                    end
                    else
                    begin
                        // keep the earlier, smaller p
                        state_next = dlog_pkg::ST_GIANT_MUL;
                    end
                end
                else if (slot_valid)
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = dlog_pkg::ST_PRB_RD;
                end
                else if (baby_reg)
                begin
                    if (q_reg == k_reg)
                    begin
                        out_next   = '0;
                        state_next = dlog_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = dlog_pkg::ST_BABY_MUL;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = dlog_pkg::ST_GIANT_MUL;
                end
            end

            dlog_pkg::ST_GIANT_MUL:
            begin
                if (mm_done)
                begin
                    if (p_reg == k_reg)
                    begin
                        run_next  = t_reg;
                        q_next    = '0;
                        baby_next = 1'b1;
                    end
                    else
                    begin
                        run_next = mm_r;
                        p_next   = p_reg + 1'b1;
                    end
                    state_next = dlog_pkg::ST_HASH1;
                end
            end

            dlog_pkg::ST_BABY_MUL:
            begin
                if (mm_done)
                begin
                    run_next   = mm_r;
                    q_next     = q_reg + 1'b1;
                    state_next = dlog_pkg::ST_HASH1;
                end
            end

            // exponent p*k - q
            dlog_pkg::ST_EXP1:
            begin
                prod_next  = (2*KB)'(hit_reg) * (2*KB)'(k_reg);
                state_next = dlog_pkg::ST_EXP2;
            end

            dlog_pkg::ST_EXP2:
            begin
                out_next.found    = 1'b1;
                out_next.exponent = prod_reg[XB-1:0] - XB'(q_reg);
                state_next        = dlog_pkg::ST_OUT;
            end

            dlog_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = dlog_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dlog_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_data = out_reg;

endmodule

[src/dlog_checker.sv]
// port-level checks of the discrete logarithm block, bound to the top level
module dlog_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input dlog_pkg::out_item_t out_data
);

    // one query at a time: never ready while a result is shown
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result item is pending");

    // a taken item closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after an item was taken");

    // exponent is zero when nothing was found
    a_zero_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.exponent == '0))
        else $error("non-zero exponent without a match");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result item changed while stalled");

endmodule

bind discrete_log_bsgs dlog_checker u_dlog_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[tb/discrete_log_bsgs_tb.sv]
// self-checking testbench of the baby-step giant-step discrete logarithm solver
module discrete_log_bsgs_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned CYCLE_LIMIT = 40_000_000;
    localparam int RANDOM_QUERIES = 100;
    localparam int DRAIN_CYCLES   = 200;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    dlog_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    dlog_pkg::out_item_t out_data;

    dlog_pkg::in_item_t  queued_queries[$];
    dlog_pkg::out_item_t awaited_logs[$];
    int        error_count = 0;
    int        logs_seen = 0;
    longint unsigned cycle_count = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        hold_left = 0;
    bit        long_hold_done = 1'b0;
    bit        stall_mode = 1'b0;

    discrete_log_bsgs DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // floor of the square root
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // expected answer of one query: smallest giant step for the first baby step
    function automatic dlog_pkg::out_item_t solve_dlog(dlog_pkg::in_item_t q_in);
        dlog_pkg::out_item_t res;
        longint unsigned m;
        longint unsigned b;
        longint unsigned t;
        longint unsigned k;
        longint unsigned gf;
        longint unsigned acc;
        longint unsigned e;
        longint unsigned sq;
        int unsigned     giant_of[longint unsigned];
        res = '0;
        m = q_in.modulus;
        if (m == 0)
            return res;
        b = q_in.base % m;
        t = q_in.target % m;
        k = int_sqrt(m) + 1;
        // base^k by square and multiply
        gf = 1 % m;
        sq = b;
        e = k;
        while (e != 0)
        begin
            if (e[0])
                gf = (gf * sq) % m;
            sq = (sq * sq) % m;
            e = e >> 1;
        end
        // giant steps, keeping the first p of each value
        acc = gf;
        for (longint unsigned p = 1; p <= k; p++)
        begin
            if (!giant_of.exists(acc))
                giant_of[acc] = 32'(p);
            acc = (acc * gf) % m;
        end
        // baby steps
        acc = t;
        for (longint unsigned j = 0; j <= k; j++)
        begin
            if (giant_of.exists(acc))
            begin
                res.found = 1'b1;
                res.exponent = dlog_pkg::EXP_BITS'(longint'(giant_of[acc]) * k - j);
                return res;
            end
            acc = (acc * b) % m;
        end
        return res;
    endfunction

    function automatic dlog_pkg::in_item_t make_query(logic [31:0] b, logic [31:0] t,
                                                      logic [31:0] m);
        dlog_pkg::in_item_t q_in;
        q_in.base = b;
        q_in.target = t;
        q_in.modulus = m;
        return q_in;
    endfunction

    // append one query to the pending list
    task automatic add_query(input logic [31:0] b, input logic [31:0] t,
                             input logic [31:0] m);
        queued_queries.insert(queued_queries.size(), make_query(b, t, m));
    endtask

    // driver: bursts of items with random gaps, valid held until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                awaited_logs.insert(awaited_logs.size(), solve_dlog(in_data));
                void'(queued_queries.pop_front());
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (queued_queries.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= queued_queries[0];
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 6);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall pattern, one long hold-off early on
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                logs_seen++;
                if (awaited_logs.size() == 0)
                begin
                    $display("%0t: unexpected item found=%0b exponent=%0d",
                             $time, out_data.found, out_data.exponent);
                    error_count++;
                end
                else
                begin
                    if (out_data.found !== awaited_logs[0].found)
                    begin
                        $display("%0t: found mismatch expected %0b actual %0b",
                                 $time, awaited_logs[0].found, out_data.found);
                        error_count++;
                    end
                    if (out_data.exponent !== awaited_logs[0].exponent)
                    begin
                        $display("%0t: exponent mismatch expected %0d actual %0d",
                                 $time, awaited_logs[0].exponent, out_data.exponent);
                        error_count++;
                    end
                    void'(awaited_logs.pop_front());
                end
            end
            if (cycle_count % 512 == 0)
                stall_mode = $urandom_range(0, 1);
            if (!long_hold_done && logs_seen == 3)
            begin
                long_hold_done = 1'b1;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_mode)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [31:0] m;
        // directed: special cases and field extremes
        add_query(32'd3, 32'd5, 32'd0);          // modulus zero
        add_query(32'd7, 32'd9, 32'd1);          // modulus one
        add_query(32'd0, 32'd0, 32'd13);
        add_query(32'd0, 32'd1, 32'd13);
        add_query(32'd0, 32'd5, 32'd13);
        add_query(32'd1, 32'd1, 32'd2);
        add_query(32'd2, 32'd3, 32'd7);          // no solution
        add_query(32'd3, 32'd4, 32'd7);
        add_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd101);
        add_query(32'hFFFF_FFFF, 32'd0, 32'd97);
        add_query(32'd5, 32'd123, 32'd65521);
        add_query(32'd2, 32'd1000, 32'd65535);
        add_query(32'd6, 32'd1, 32'd36);
        add_query(32'hAAAA_AAAA, 32'h5555_5555, 32'd4096);
        add_query(32'h5555_5555, 32'hAAAA_AAAA, 32'd4095);
        add_query($urandom, $urandom, 32'hFFFF_FFFF); // largest modulus
        // random: mostly small moduli, a few mid-size
        for (int i = 0; i < RANDOM_QUERIES; i++)
        begin
            case ($urandom_range(0, 9))
                0:       m = $urandom_range(1, 16);
                9:       m = $urandom_range(4097, 65535);
                default: m = $urandom_range(2, 4096);
            endcase
            add_query($urandom, $urandom, m);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (queued_queries.size() > 0 || in_valid || awaited_logs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
